// ===== src/tsrd_pkg.sv =====
// shared constants, widths and codes for the timestamped sample-rate decimator
package tsrd_pkg;

  // decimation accumulator fraction bits (valid range 8 to 24)
  localparam int unsigned ACC_FRAC_BITS = 16;
  localparam int unsigned ACC_W         = ACC_FRAC_BITS + 1;

  // field and register widths
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned GAP_W      = 32;
  localparam int unsigned REASON_W   = 2;
  localparam int unsigned TARGET_W   = 19;
  localparam int unsigned ADV_W      = 21;
  localparam int unsigned PERIOD_W   = 28;
  localparam int unsigned Q8_BITS    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 21;

  // serial datapath widths
  localparam int unsigned MUL_W = TARGET_W + PERIOD_W;  // target times period
  localparam int unsigned DIV_W = 38;                   // holds the live rate denominator
  localparam int unsigned QUO_W = 36;                   // period average numerator
  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  // drop reason codes
  localparam logic [REASON_W-1:0] RSN_KEPT  = 2'd0;
  localparam logic [REASON_W-1:0] RSN_DUP   = 2'd1;
  localparam logic [REASON_W-1:0] RSN_DECIM = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADVERTISED = 2'd2;

  // arithmetic constants
  localparam logic [TIME_W-1:0] ONE_SEC_US    = 48'd1000000;
  localparam logic [DIV_W-1:0]  LIVE_RATE_DEN = 38'd256000000000;
  localparam int unsigned       EMA_MUL       = 99;
  localparam int unsigned       EMA_MUL_STEPS = 7;
  localparam int unsigned       EMA_DIV       = 100;
  localparam int unsigned       EMA_ROUND     = 50;

  localparam logic [ACC_W-1:0] RATIO_ONE = ACC_W'(1) << ACC_FRAC_BITS;
  localparam logic [ACC_W:0]   ACC_UNIT  = (ACC_W + 1)'(1) << ACC_FRAC_BITS;

endpackage

// ===== src/tsrd_if.sv =====
// valid/ready channel interfaces for samples, results and register writes
interface tsrd_in_if;
  import tsrd_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] sample_time_us;

  modport source (output valid, output sample_time_us, input ready);
  modport sink   (input valid, input sample_time_us, output ready);
endinterface

interface tsrd_out_if;
  import tsrd_pkg::*;
  logic                valid;
  logic                ready;
  logic                keep;
  logic [REASON_W-1:0] drop_reason;
  logic [TIME_W-1:0]   kept_time_us;
  logic [GAP_W-1:0]    gap_us;

  modport source (output valid, output keep, output drop_reason, output kept_time_us,
                  output gap_us, input ready);
  modport sink   (input valid, input keep, input drop_reason, input kept_time_us,
                  input gap_us, output ready);
endinterface

interface tsrd_cfg_if;
  import tsrd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/timestamped_sample_rate_decimator.sv =====
// timestamped sample-rate decimator top level with serial multiply and divide
//
//   channel    dir  handshake      word
//   sample_i   in   valid/ready    sample_time_us
//   result_o   out  valid/ready    keep, drop_reason, kept_time_us, gap_us
//   cfg_i      in   valid/ready    index, data (ready always high)
//
// one word in flight; a sample dropped as duplicate goes from the check to done, a trivial
// ratio adds the ratio select and accumulate steps, and live mode with a period update adds
// the period multiply and divide as well; the shift-add multiplier (1 bit per cycle) and the
// restoring divider (1 quotient bit per cycle) compute the period average and the keep
// ratio
// a finished result waits in the output register while the next sample is taken
// reset clears the config registers, history, period estimate and accumulator
module timestamped_sample_rate_decimator (
  input logic        clk_i,
  input logic        rst_ni,
  tsrd_in_if.sink    sample_i,
  tsrd_out_if.source result_o,
  tsrd_cfg_if.sink   cfg_i
);
  import tsrd_pkg::*;

  // sequencer codes
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHECK = 4'd1;
  localparam logic [3:0] ST_MUL99 = 4'd2;
  localparam logic [3:0] ST_DIVP  = 4'd3;
  localparam logic [3:0] ST_RSEL  = 4'd4;
  localparam logic [3:0] ST_MULTP = 4'd5;
  localparam logic [3:0] ST_DIVR  = 4'd6;
  localparam logic [3:0] ST_ACC   = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic [3:0] state_q, state_d;

  // config registers
  logic                batch_q;
  logic [TARGET_W-1:0] target_q;
  logic [ADV_W-1:0]    adv_q;

  // history and estimator state
  logic [TIME_W-1:0]   ls_time_q, ls_time_d;
  logic                ls_valid_q, ls_valid_d;
  logic [TIME_W-1:0]   lk_time_q, lk_time_d;
  logic                lk_valid_q, lk_valid_d;
  logic [PERIOD_W-1:0] period_q, period_d;
  logic [ACC_W-1:0]    dacc_q, dacc_d;

  // per-sample working registers
  logic [TIME_W-1:0]   t_q, t_d;
  logic [GAP_W-1:0]    gap_q, gap_d;
  logic [REASON_W-1:0] reason_q, reason_d;
  logic                keep_q, keep_d;
  logic [ACC_W-1:0]    ratio_q, ratio_d;

  // serial multiplier and divider
  logic [MUL_W-1:0]    mul_acc_q, mul_acc_d;
  logic [MUL_W-1:0]    mcand_q, mcand_d;
  logic [TARGET_W-1:0] mplier_q, mplier_d;
  logic [DIV_W-1:0]    rem_q, rem_d;
  logic [QUO_W-1:0]    quo_q, quo_d;
  logic [DIV_W-1:0]    den_q, den_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic                out_keep_q;
  logic [REASON_W-1:0] out_reason_q;
  logic [TIME_W-1:0]   out_time_q;
  logic [GAP_W-1:0]    out_gap_q;
  logic                out_load;

  // datapath helpers
  logic [TIME_W-1:0] kept_diff;
  logic [TIME_W-1:0] seen_diff;
  logic [GAP_W-1:0]  gap_val;
  logic              dup;
  logic [MUL_W-1:0]  mul_sum;
  logic [DIV_W:0]    div_trial;
  logic [DIV_W:0]    div_diff;
  logic              div_ge;
  logic [DIV_W-1:0]  rem_next;
  logic [QUO_W-1:0]  quo_next;
  logic [ACC_W:0]    acc_sum;
  logic [ACC_W:0]    acc_wrap;
  logic              rate_trivial;

  assign sample_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready    = 1'b1;

  assign result_o.valid        = out_valid_q;
  assign result_o.keep         = out_keep_q;
  assign result_o.drop_reason  = out_reason_q;
  assign result_o.kept_time_us = out_time_q;
  assign result_o.gap_us       = out_gap_q;

  // gap to last kept sample, zero when older, saturating at the top
  assign kept_diff = t_q - lk_time_q;
  assign seen_diff = t_q - ls_time_q;
  always_comb begin
    if (t_q < lk_time_q) begin
      gap_val = '0;
    end else if (|kept_diff[TIME_W-1:GAP_W]) begin
      gap_val = '1;
    end else begin
      gap_val = kept_diff[GAP_W-1:0];
    end
  end

  // batch mode judges repeats against the last kept time, live against last seen
  assign dup = batch_q ? (lk_valid_q && (t_q <= lk_time_q))
                       : (ls_valid_q && (t_q <= ls_time_q));

  // one shift-add step of the multiplier
  assign mul_sum = mul_acc_q + (mplier_q[0] ? mcand_q : '0);

  // one restoring step of the divider
  assign div_trial = {rem_q, quo_q[QUO_W-1]};
  assign div_diff  = div_trial - {1'b0, den_q};
  assign div_ge    = (div_trial >= {1'b0, den_q});
  assign rem_next  = div_ge ? div_diff[DIV_W-1:0] : div_trial[DIV_W-1:0];
  assign quo_next  = {quo_q[QUO_W-2:0], div_ge};

  // fractional accumulator
  assign acc_sum  = {1'b0, dacc_q} + {1'b0, ratio_q};
  assign acc_wrap = acc_sum - ACC_UNIT;

  // ratio from advertised rate is one when target >= rate, or either is zero
  assign rate_trivial = (target_q == '0) || (adv_q == '0) ||
                        ({{(ADV_W - TARGET_W){1'b0}}, target_q} >= adv_q);

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || result_o.ready);

  always_comb begin
    state_d     = state_q;
    ls_time_d   = ls_time_q;
    ls_valid_d  = ls_valid_q;
    lk_time_d   = lk_time_q;
    lk_valid_d  = lk_valid_q;
    period_d    = period_q;
    dacc_d      = dacc_q;
    t_d         = t_q;
    gap_d       = gap_q;
    reason_d    = reason_q;
    keep_d      = keep_q;
    ratio_d     = ratio_q;
    mul_acc_d   = mul_acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    den_d       = den_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !result_o.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (sample_i.valid) begin
          t_d     = sample_i.sample_time_us;
          state_d = ST_CHECK;
        end
      end

      ST_CHECK: begin
        gap_d = gap_val;
        if (dup) begin
          keep_d   = 1'b0;
          reason_d = RSN_DUP;
          state_d  = ST_DONE;
        end else if (!batch_q) begin
          ls_time_d  = t_q;
          ls_valid_d = 1'b1;
          state_d    = ST_RSEL;
          if (ls_valid_q && (seen_diff < ONE_SEC_US)) begin
            if (period_q == '0) begin
              period_d = {seen_diff[PERIOD_W-Q8_BITS-1:0], {Q8_BITS{1'b0}}};
            end else begin
              // 99 * period + 256 * dt + 50, then divide by 100
              mul_acc_d = MUL_W'({seen_diff[PERIOD_W-Q8_BITS-1:0], Q8_BITS'(EMA_ROUND)});
              mcand_d   = MUL_W'(period_q);
              mplier_d  = TARGET_W'(EMA_MUL);
              cnt_d     = CNT_W'(EMA_MUL_STEPS);
              state_d   = ST_MUL99;
            end
          end
        end else begin
          state_d = ST_RSEL;
        end
      end

      ST_MUL99: begin
        mul_acc_d = mul_sum;
        mcand_d   = mcand_q << 1;
        mplier_d  = mplier_q >> 1;
        cnt_d     = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          rem_d   = '0;
          quo_d   = mul_sum[QUO_W-1:0];
          den_d   = DIV_W'(EMA_DIV);
          cnt_d   = CNT_W'(QUO_W);
          state_d = ST_DIVP;
        end
      end

      ST_DIVP: begin
        rem_d = rem_next;
        quo_d = quo_next;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          period_d = quo_next[PERIOD_W-1:0];
          state_d  = ST_RSEL;
        end
      end

      ST_RSEL: begin
        if (!batch_q && (period_q != '0)) begin
          if (target_q == '0) begin
            ratio_d = RATIO_ONE;
            state_d = ST_ACC;
          end else begin
            mul_acc_d = '0;
            mcand_d   = MUL_W'(period_q);
            mplier_d  = target_q;
            cnt_d     = CNT_W'(TARGET_W);
            state_d   = ST_MULTP;
          end
        end else if (rate_trivial) begin
          ratio_d = RATIO_ONE;
          state_d = ST_ACC;
        end else begin
          // target below rate, so the quotient has no integer part
          rem_d   = DIV_W'(target_q);
          quo_d   = '0;
          den_d   = DIV_W'(adv_q);
          cnt_d   = CNT_W'(ACC_FRAC_BITS);
          state_d = ST_DIVR;
        end
      end

      ST_MULTP: begin
        mul_acc_d = mul_sum;
        mcand_d   = mcand_q << 1;
        mplier_d  = mplier_q >> 1;
        cnt_d     = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          if (mul_sum >= MUL_W'(LIVE_RATE_DEN)) begin
            ratio_d = RATIO_ONE;
            state_d = ST_ACC;
          end else begin
            rem_d   = mul_sum[DIV_W-1:0];
            quo_d   = '0;
            den_d   = LIVE_RATE_DEN;
            cnt_d   = CNT_W'(ACC_FRAC_BITS);
            state_d = ST_DIVR;
          end
        end
      end

      ST_DIVR: begin
        rem_d = rem_next;
        quo_d = quo_next;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          ratio_d = {1'b0, quo_next[ACC_FRAC_BITS-1:0]};
          state_d = ST_ACC;
        end
      end

      ST_ACC: begin
        if (acc_sum < ACC_UNIT) begin
          dacc_d   = acc_sum[ACC_W-1:0];
          keep_d   = 1'b0;
          reason_d = RSN_DECIM;
        end else begin
          dacc_d     = acc_wrap[ACC_W-1:0];
          lk_time_d  = t_q;
          lk_valid_d = 1'b1;
          keep_d     = 1'b1;
          reason_d   = RSN_KEPT;
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and model state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      batch_q     <= 1'b0;
      target_q    <= '0;
      adv_q       <= '0;
      ls_time_q   <= '0;
      ls_valid_q  <= 1'b0;
      lk_time_q   <= '0;
      lk_valid_q  <= 1'b0;
      period_q    <= '0;
      dacc_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ls_time_q   <= ls_time_d;
      ls_valid_q  <= ls_valid_d;
      lk_time_q   <= lk_time_d;
      lk_valid_q  <= lk_valid_d;
      period_q    <= period_d;
      dacc_q      <= dacc_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CFG_BATCH_MODE: batch_q  <= cfg_i.data[0];
          CFG_TARGET:     target_q <= cfg_i.data[TARGET_W-1:0];
          CFG_ADVERTISED: adv_q    <= cfg_i.data[ADV_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    t_q       <= t_d;
    gap_q     <= gap_d;
    reason_q  <= reason_d;
    keep_q    <= keep_d;
    ratio_q   <= ratio_d;
    mul_acc_q <= mul_acc_d;
    mcand_q   <= mcand_d;
    mplier_q  <= mplier_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    den_q     <= den_d;
    cnt_q     <= cnt_d;
    if (out_load) begin
      out_keep_q   <= keep_q;
      out_reason_q <= reason_q;
      out_time_q   <= t_q;
      out_gap_q    <= gap_q;
    end
  end

endmodule

// ===== src/tsrd_check.sv =====
// port-level checker for the decimator and its bind
module tsrd_check (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_keep,
  input logic [tsrd_pkg::REASON_W-1:0] out_reason,
  input logic [tsrd_pkg::TIME_W-1:0]   out_time,
  input logic [tsrd_pkg::GAP_W-1:0]    out_gap
);
  import tsrd_pkg::*;

  // keep flag agrees with the drop reason
  a_keep_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_keep == (out_reason == RSN_KEPT)))
    else $error("keep flag disagrees with drop reason");

  // no undefined reason code
  a_reason_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_reason == RSN_KEPT || out_reason == RSN_DUP ||
                   out_reason == RSN_DECIM))
    else $error("undefined drop reason");

  // one sample at a time: ready drops right after a word is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second sample taken while one is in progress");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_time) && $stable(out_gap)))
    else $error("stalled result changed");

endmodule

bind timestamped_sample_rate_decimator tsrd_check u_tsrd_check (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (sample_i.valid),
  .in_ready   (sample_i.ready),
  .out_valid  (result_o.valid),
  .out_ready  (result_o.ready),
  .out_keep   (result_o.keep),
  .out_reason (result_o.drop_reason),
  .out_time   (result_o.kept_time_us),
  .out_gap    (result_o.gap_us)
);

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the timestamped sample-rate decimator
module tb_top;
  import tsrd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;  // cycles with no handshake at all
  localparam int unsigned DRAIN_CYCLES   = 120;   // a little over the slowest sample
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam int unsigned RANDOM_PHASES  = 11;
  localparam int unsigned PHASE_SAMPLES  = 150;

  // index past the end of the register list, the block must ignore it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [GAP_W-1:0]     GAP_SAT    = '1;

  // one decision word as the block reports it
  typedef struct {
    logic                keep;
    logic [REASON_W-1:0] reason;
    logic [TIME_W-1:0]   stamp;
    logic [GAP_W-1:0]    gap;
  } decision_t;

  // one entry of the stimulus plan: a register write or a sample
  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    logic [TIME_W-1:0]     stamp;
  } plan_entry_t;

  logic clk_i;
  logic rst_ni;

  tsrd_in_if  smp_if ();
  tsrd_out_if res_if ();
  tsrd_cfg_if cfg_if ();

  timestamped_sample_rate_decimator dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  plan_entry_t sample_plan[$];        // filled once at time zero, drained by the driver
  decision_t   pending_decisions[$];  // predicted words, oldest first
  int unsigned plan_samples;
  int unsigned samples_taken;         // driver side, blocking updates
  int unsigned decisions_seen;        // monitor side, nonblocking updates
  int unsigned mismatches;
  int unsigned quiet_cycles;
  logic [TIME_W-1:0] cursor_t;        // newest stamp of the well-formed stream

  // predictor copy of the registers and the decimation state, all zero at reset
  bit                batch_reg;
  bit [TARGET_W-1:0] target_reg;
  bit [ADV_W-1:0]    adv_reg;
  bit [TIME_W-1:0]   seen_t;
  bit                seen_ok;
  bit [TIME_W-1:0]   kept_t;
  bit                kept_ok;
  bit [PERIOD_W-1:0] period_q8;
  bit [ACC_W-1:0]    frac_acc;

  // ---------------------------------------------------------------------------
  // keep ratio prediction
  // ---------------------------------------------------------------------------

  // target over a nominal sensor rate, keep all when either is zero
  function automatic logic [ACC_W-1:0] rate_ratio(bit [ADV_W-1:0] rate_mhz);
    longint unsigned num;
    longint unsigned r;
    if (target_reg == 0 || rate_mhz == 0) return RATIO_ONE;
    num = target_reg;
    num = num << ACC_FRAC_BITS;
    r = num / rate_mhz;
    return (r > longint'(RATIO_ONE)) ? RATIO_ONE : r[ACC_W-1:0];
  endfunction

  // target times measured period; mHz * us * 2^8 scaled down by 256e9
  function automatic logic [ACC_W-1:0] period_ratio();
    longint unsigned num;
    longint unsigned r;
    if (target_reg == 0) return RATIO_ONE;
    num = target_reg;
    num = num * period_q8;
    if (num >= LIVE_RATE_DEN) return RATIO_ONE;
    r = (num << ACC_FRAC_BITS) / LIVE_RATE_DEN;
    return r[ACC_W-1:0];
  endfunction

  function automatic void apply_write(logic [CFG_IDX_W-1:0] index,
                                      logic [CFG_DATA_W-1:0] data);
    case (index)
      CFG_BATCH_MODE: batch_reg  = data[0];
      CFG_TARGET:     target_reg = data[TARGET_W-1:0];
      CFG_ADVERTISED: adv_reg    = data[ADV_W-1:0];
      default: ;
    endcase
  endfunction

  // decide one sample and advance the predictor state
  function automatic decision_t decimate_sample(logic [TIME_W-1:0] t);
    decision_t         d;
    logic [TIME_W-1:0] dt;
    logic [TIME_W-1:0] since_kept;
    logic [ACC_W:0]    sum;
    logic [ACC_W-1:0]  ratio;
    longint unsigned   ema;
    d.keep   = 1'b0;
    d.reason = RSN_DECIM;
    d.stamp  = t;
    d.gap    = '0;
    // gap to the last kept stamp, zero when this one is older
    if (t >= kept_t) begin
      since_kept = t - kept_t;
      d.gap = (since_kept > GAP_SAT) ? GAP_SAT : since_kept[GAP_W-1:0];
    end
    if (!batch_reg) begin
      if (seen_ok && t <= seen_t) begin
        d.reason = RSN_DUP;
        return d;
      end
      // period average only over gaps shorter than a second
      if (seen_ok) begin
        dt = t - seen_t;
        if (dt < ONE_SEC_US) begin
          if (period_q8 == 0) begin
            period_q8 = PERIOD_W'(dt << Q8_BITS);
          end else begin
            ema = EMA_MUL * period_q8 + (dt << Q8_BITS) + EMA_ROUND;
            period_q8 = PERIOD_W'(ema / EMA_DIV);
          end
        end
      end
      seen_t  = t;
      seen_ok = 1'b1;
      ratio = (period_q8 != 0) ? period_ratio() : rate_ratio(adv_reg);
    end else begin
      if (kept_ok && t <= kept_t) begin
        d.reason = RSN_DUP;
        return d;
      end
      ratio = rate_ratio(adv_reg);
    end
    sum = frac_acc + ratio;
    if (sum < ACC_UNIT) begin
      frac_acc = sum[ACC_W-1:0];
      return d;
    end
    frac_acc = ACC_W'(sum - ACC_UNIT);
    kept_t   = t;
    kept_ok  = 1'b1;
    d.keep   = 1'b1;
    d.reason = RSN_KEPT;
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // plan building
  // ---------------------------------------------------------------------------

  function automatic void add_sample(logic [TIME_W-1:0] t);
    plan_entry_t e;
    e.is_write = 1'b0;
    e.index    = '0;
    e.data     = '0;
    e.stamp    = t;
    sample_plan.push_back(e);
    plan_samples++;
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] index,
                                    logic [CFG_DATA_W-1:0] data);
    plan_entry_t e;
    e.is_write = 1'b1;
    e.index    = index;
    e.data     = data;
    e.stamp    = '0;
    sample_plan.push_back(e);
  endfunction

  function automatic void advance(logic [TIME_W-1:0] delta);
    cursor_t = cursor_t + delta;
    add_sample(cursor_t);
  endfunction

  // mostly a jittered stream around the nominal period, with some repeats,
  // stale stamps and long silences mixed in
  function automatic void add_stream(int unsigned count, int unsigned dt_nom);
    int unsigned i;
    int unsigned roll;
    for (i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        add_sample(cursor_t - TIME_W'($urandom_range(0, 2 * dt_nom)));
      end else if (roll < 6) begin
        // silence of a second or more, sometimes past what the gap field holds
        if ($urandom_range(3) == 0) advance(48'h1_0000_0000 + TIME_W'($urandom));
        else advance(TIME_W'($urandom_range(1000000, 3000000)));
      end else if (roll < 7) begin
        add_sample(cursor_t & TIME_W'({$urandom, $urandom}));
      end else begin
        advance(TIME_W'(dt_nom - dt_nom / 8 + $urandom_range(0, dt_nom / 4)));
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // idling schedule: sender light and receiver heavy, then swapped, then none
  // ---------------------------------------------------------------------------

  function automatic int unsigned sender_idle_pct(int unsigned progress);
    if (progress < plan_samples / 3) return 22;
    if (progress < 2 * plan_samples / 3) return 50;
    return 0;
  endfunction

  function automatic int unsigned receiver_idle_pct(int unsigned progress);
    if (progress < plan_samples / 3) return 50;
    if (progress < 2 * plan_samples / 3) return 22;
    return 0;
  endfunction

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------

  initial begin
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // driver: samples and register writes from the plan
  // a word is predicted on the edge where the block accepts it; register
  // writes go out only once every predicted word has come back
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin : sample_driver
    plan_entry_t nxt;
    logic        smp_valid_nx;
    logic        cfg_valid_nx;
    if (!rst_ni) begin
      smp_if.valid          <= 1'b0;
      smp_if.sample_time_us <= '0;
      cfg_if.valid          <= 1'b0;
      cfg_if.index          <= '0;
      cfg_if.data           <= '0;
    end else begin
      smp_valid_nx = smp_if.valid;
      cfg_valid_nx = cfg_if.valid;
      if (cfg_if.valid && cfg_if.ready) begin
        apply_write(cfg_if.index, cfg_if.data);
        cfg_valid_nx = 1'b0;
      end
      if (smp_if.valid && smp_if.ready) begin
        pending_decisions.push_back(decimate_sample(smp_if.sample_time_us));
        samples_taken++;
        smp_valid_nx = 1'b0;
      end
      if (!smp_valid_nx && !cfg_valid_nx && sample_plan.size() != 0) begin
        nxt = sample_plan[0];
        if (nxt.is_write) begin
          // block idle: nothing accepted is still owed a result
          if (samples_taken == decisions_seen) begin
            cfg_valid_nx = 1'b1;
            cfg_if.index <= nxt.index;
            cfg_if.data  <= nxt.data;
            void'(sample_plan.pop_front());
          end
        end else if ($urandom_range(99) >= sender_idle_pct(samples_taken)) begin
          smp_valid_nx = 1'b1;
          smp_if.sample_time_us <= nxt.stamp;
          void'(sample_plan.pop_front());
        end
      end
      // single nonblocking write per valid per edge
      smp_if.valid <= smp_valid_nx;
      cfg_if.valid <= cfg_valid_nx;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every accepted word against the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    decision_t want;
    if (!rst_ni) begin
      res_if.ready   <= 1'b0;
      decisions_seen <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        decisions_seen <= decisions_seen + 1;
        if (pending_decisions.size() == 0) begin
          flag_error($sformatf("word %0d arrived with no sample pending, stamp %h",
                               decisions_seen, res_if.kept_time_us));
        end else begin
          want = pending_decisions.pop_front();
          if (res_if.keep !== want.keep || res_if.drop_reason !== want.reason ||
              res_if.kept_time_us !== want.stamp || res_if.gap_us !== want.gap) begin
            flag_error($sformatf({"word %0d mismatch: expected keep %0b reason %0d ",
                                  "stamp %h gap %0d, got keep %0b reason %0d ",
                                  "stamp %h gap %0d"},
                                 decisions_seen, want.keep, want.reason, want.stamp,
                                 want.gap, res_if.keep, res_if.drop_reason,
                                 res_if.kept_time_us, res_if.gap_us));
          end
        end
      end
      res_if.ready <= ($urandom_range(99) >= receiver_idle_pct(decisions_seen));
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: a stuck handshake ends the run
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni || (smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // plan, reset release and end of run
  // ---------------------------------------------------------------------------

  initial begin : plan_and_finish
    int unsigned      p;
    int unsigned      dt_nom;
    int unsigned      rate;
    int unsigned      tgt;
    int unsigned      adv;
    bit               mode;
    logic [TIME_W-1:0] kept_mark;

    // live, 100 Hz wanted from a sensor advertised at 400 Hz
    add_write(CFG_TARGET, 21'd100000);
    add_write(CFG_ADVERTISED, 21'd400000);
    add_write(CFG_BATCH_MODE, 21'd0);
    add_sample(48'd100);      // first sample: no repeat test, advertised rate used
    add_sample(48'd100);      // repeated stamp
    add_sample(48'd50);       // out of order
    add_sample(48'd2600);     // first gap seeds the period estimate
    add_sample(48'd5100);
    add_sample(48'd7600);     // accumulator reaches one, kept
    add_sample(48'd7000);     // older than the last kept stamp, gap reads zero
    add_sample(48'd1107600);  // gap over a second, estimate held
    add_sample(48'd1110100);

    // target zero keeps everything; then a gap beyond 32 bits saturates
    add_write(CFG_TARGET, 21'd0);
    cursor_t = 48'd1110100;
    advance(48'd2500);
    advance(48'h2_0000_0000);

    // target above its range with a known period caps the ratio at one
    add_write(CFG_TARGET, 21'h1FFFFF);
    advance(48'd2500);
    kept_mark = cursor_t;

    // batch, tiny target over an oversized rate: ratio floors to zero
    add_write(CFG_BATCH_MODE, 21'h1FFFFF);
    add_write(CFG_TARGET, 21'd1);
    add_write(CFG_ADVERTISED, 21'h1FFFFF);
    advance(48'd1000);
    add_sample(cursor_t);       // repeat of a dropped stamp is still newer than kept
    add_sample(kept_mark);      // equal to the last kept stamp
    add_sample(kept_mark - 1);

    // batch with unknown advertised rate keeps all, then a 0.2 ratio
    add_write(CFG_TARGET, 21'd5);
    add_write(CFG_ADVERTISED, 21'd0);
    advance(48'd1000);
    add_write(CFG_TARGET, 21'd400000);
    add_write(CFG_ADVERTISED, 21'd2000000);
    advance(48'd500);
    advance(48'd500);
    advance(48'd500);

    // write past the register list, then back to live on stale history
    add_write(CFG_UNUSED, CFG_DATA_W'($urandom));
    add_write(CFG_BATCH_MODE, 21'd0);
    advance(48'd500);

    // random phases: stamps continue high in the 48-bit range
    cursor_t = {1'b1, 7'd0, 8'($urandom), 32'($urandom)};
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(3))
        0:       dt_nom = 500;
        1:       dt_nom = 2500;
        2:       dt_nom = 10000;
        default: dt_nom = $urandom_range(500, 20000);
      endcase
      rate = 1000000000 / dt_nom;  // nominal sensor rate in mHz
      case (p)
        0:       tgt = 0;
        1:       tgt = 'h7FFFF;
        2:       tgt = 1;
        3:       tgt = 400000;
        default: tgt = $urandom_range(1, (rate < 400000) ? rate : 400000);
      endcase
      case (p)
        4:       adv = 0;
        5:       adv = 'h1FFFFF;
        6:       adv = 2000000;
        default: adv = rate * $urandom_range(80, 120) / 100;
      endcase
      if (adv > 'h1FFFFF) adv = 'h1FFFFF;
      mode = p[0];
      add_write(CFG_BATCH_MODE, CFG_DATA_W'({$urandom, mode}));
      add_write(CFG_TARGET, CFG_DATA_W'({$urandom, TARGET_W'(tgt)}));
      add_write(CFG_ADVERTISED, CFG_DATA_W'(adv));
      if (p % 3 == 2) add_write(CFG_UNUSED, CFG_DATA_W'($urandom));
      add_stream(PHASE_SAMPLES, dt_nom);
    end

    // top of the stamp range, live and keep all
    add_write(CFG_BATCH_MODE, 21'd0);
    add_write(CFG_TARGET, 21'd0);
    add_sample('1);
    add_sample('1);
    add_sample(48'hFFFF_FFFF_FFFE);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sample on the falling edge so the clocked blocks have settled
    do @(negedge clk_i);
    while (sample_plan.size() != 0 || smp_if.valid || samples_taken != decisions_seen);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (pending_decisions.size() != 0)
      flag_error($sformatf("%0d predicted words never arrived", pending_decisions.size()));

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
